/* hdl/top_k_keyed_frequency_list_defines.svh */
// assertion macros for the top-k keyed frequency list checker
// expects clk and rst_n in the scope of each use
`ifndef TOP_K_KEYED_FREQUENCY_LIST_DEFINES_SVH
`define TOP_K_KEYED_FREQUENCY_LIST_DEFINES_SVH

// same-cycle implication
`define TKFL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tkfl check failed");

// next-cycle implication
`define TKFL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tkfl check failed");

`endif

/* hdl/tkfl_pkg.sv */
// shared types and constants for the top-k keyed frequency list
// no dependencies
`timescale 1ns / 1ps

package tkfl_pkg;

    localparam int MAX_SIZE = 8;
    localparam int KEY_W    = 32;
    localparam int FREQ_W   = 16;
    localparam int POS_W    = 6;
    localparam int FILL_W   = 7;
    localparam int HELD_W   = $clog2(MAX_SIZE + 1);

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_CLEAR  = 2'd1,
        KIND_READ   = 2'd2,
        KIND_LOOKUP = 2'd3
    } kind_t;

    // command fields and list-wide decisions seen by every cell
    typedef struct packed {
        kind_t               kind;
        logic [KEY_W-1:0]    key;
        logic [FREQ_W-1:0]   freq;
        logic [POS_W-1:0]    pos;
        logic [FILL_W-1:0]   held;
        logic                room;
        logic                existing;
        logic                write_en;
    } ctrl_t;

    // data handed from one cell to its right neighbor
    typedef struct packed {
        logic                cond;
        logic                match_any;
        logic                raise_ok;
        logic                hit;
        logic [POS_W-1:0]    hit_idx;
        logic [KEY_W-1:0]    hit_key;
        logic [FREQ_W-1:0]   hit_freq;
        logic [KEY_W-1:0]    nbr_key;
        logic [FREQ_W-1:0]   nbr_freq;
    } link_t;

endpackage

/* hdl/tkfl_cell.sv */
// one list slot: stored entry, compare against the command, shift or insert
// depends on tkfl_pkg
`timescale 1ns / 1ps

module tkfl_cell
(
    input  logic                clk,
    input  logic [tkfl_pkg::POS_W-1:0] cell_idx,
    input  tkfl_pkg::ctrl_t     ctrl,
    input  tkfl_pkg::link_t     link_in,
    output tkfl_pkg::link_t     link_out
);

    logic [tkfl_pkg::KEY_W-1:0]  key_reg;
    logic [tkfl_pkg::KEY_W-1:0]  key_next;
    logic [tkfl_pkg::FREQ_W-1:0] freq_reg;
    logic [tkfl_pkg::FREQ_W-1:0] freq_next;
    logic [tkfl_pkg::FILL_W-1:0] idx_ext;
    logic                        valid;
    logic                        eq;
    logic                        lt;
    logic                        cond;
    logic                        bound;
    logic                        take_new;
    logic                        shift;
    logic                        sel;

    always_comb
    begin
        idx_ext  = {1'b0, cell_idx};
        valid    = idx_ext < ctrl.held;
        eq       = valid && (key_reg == ctrl.key);
        lt       = valid && (freq_reg < ctrl.freq);
        // an append lands at the first free slot when nothing is lower
        cond     = lt || (!ctrl.existing && ctrl.room && (idx_ext == ctrl.held));
        bound    = ctrl.existing ? !link_in.match_any : (idx_ext <= ctrl.held);
        take_new = cond && !link_in.cond;
        shift    = link_in.cond && bound;

        key_next  = key_reg;
        freq_next = freq_reg;
        if (ctrl.write_en && take_new)
        begin
            key_next  = ctrl.key;
            freq_next = ctrl.freq;
        end
        else if (ctrl.write_en && shift)
        begin
            key_next  = link_in.nbr_key;
            freq_next = link_in.nbr_freq;
        end

        sel = ((ctrl.kind == tkfl_pkg::KIND_LOOKUP) && eq) ||
              ((ctrl.kind == tkfl_pkg::KIND_READ) && valid && (ctrl.pos == cell_idx));

        link_out           = link_in;
        link_out.cond      = cond;
        link_out.match_any = link_in.match_any || eq;
        link_out.raise_ok  = link_in.raise_ok || (eq && lt);
        link_out.hit       = link_in.hit || sel;
        link_out.nbr_key   = key_reg;
        link_out.nbr_freq  = freq_reg;
        if (!link_in.hit && sel)
        begin
            link_out.hit_idx  = cell_idx;
            link_out.hit_key  = key_reg;
            link_out.hit_freq = freq_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        freq_reg <= freq_next;
    end

endmodule

/* hdl/top_k_keyed_frequency_list.sv */
// top level of the top-k keyed frequency list: control, fill count, result register
// depends on tkfl_pkg and tkfl_cell
//
// usage:
//   command channel: drive kind, word_key, frequency and position with start high;
//   the beat is taken at a rising edge with start high and busy low. busy stays low,
//   so a new command may follow in every cycle.
//   kinds: add or raise, clear, read entry at position, look up word_key.
//   result channel: done is high for exactly one cycle, the cycle after the command
//   beat, with accepted, found, entry_index, entry_word, entry_frequency and
//   fill_count valid in that cycle. throughput one command per cycle.
//   search, insert and re-sort happen in one pass through the row of cells:
//   each cell compares its entry with the command and either keeps its entry, takes
//   the new one or takes its left neighbor's, so the ripple through the row sets the
//   cycle time.
//   reset empties the list (fill count zero) and drops any pending result; stored
//   entries are not cleared. the receiver cannot stall: each result beat is taken
//   in the cycle it is shown.
`timescale 1ns / 1ps

module top_k_keyed_frequency_list
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    kind,
    input  logic [tkfl_pkg::KEY_W-1:0]    word_key,
    input  logic [tkfl_pkg::FREQ_W-1:0]   frequency,
    input  logic [tkfl_pkg::POS_W-1:0]    position,
    output logic                          done,
    output logic                          accepted,
    output logic                          found,
    output logic [tkfl_pkg::POS_W-1:0]    entry_index,
    output logic [tkfl_pkg::KEY_W-1:0]    entry_word,
    output logic [tkfl_pkg::FREQ_W-1:0]   entry_frequency,
    output logic [tkfl_pkg::FILL_W-1:0]   fill_count
);

    tkfl_pkg::ctrl_t               ctrl;
    tkfl_pkg::link_t               links [tkfl_pkg::MAX_SIZE+1];
    tkfl_pkg::link_t               last;
    tkfl_pkg::kind_t               cmd_kind;
    logic                          take;
    logic                          add_ok;
    logic [tkfl_pkg::HELD_W-1:0]   held_reg;
    logic [tkfl_pkg::HELD_W-1:0]   held_next;
    logic                          done_reg;
    logic                          accepted_reg;
    logic                          found_reg;
    logic [tkfl_pkg::POS_W-1:0]    index_reg;
    logic [tkfl_pkg::KEY_W-1:0]    word_reg;
    logic [tkfl_pkg::FREQ_W-1:0]   freq_reg;

    assign busy     = 1'b0;
    assign take     = start && !busy;
    assign cmd_kind = tkfl_pkg::kind_t'(kind);
    assign links[0] = '0;
    assign last     = links[tkfl_pkg::MAX_SIZE];

    always_comb
    begin
        ctrl.kind     = cmd_kind;
        ctrl.key      = word_key;
        ctrl.freq     = frequency;
        ctrl.pos      = position;
        ctrl.held     = tkfl_pkg::FILL_W'(held_reg);
        ctrl.room     = held_reg < tkfl_pkg::HELD_W'(tkfl_pkg::MAX_SIZE);
        ctrl.existing = last.match_any;
        // when full, the last cell's compare decides replacement
        add_ok        = last.match_any ? last.raise_ok : (ctrl.room || last.cond);
        ctrl.write_en = take && (cmd_kind == tkfl_pkg::KIND_ADD) && add_ok;

        held_next = held_reg;
        if (take && (cmd_kind == tkfl_pkg::KIND_CLEAR))
        begin
            held_next = '0;
        end
        else if (ctrl.write_en && !last.match_any && ctrl.room)
        begin
            held_next = held_reg + 1'b1;
        end
    end

    for (genvar i = 0; i < tkfl_pkg::MAX_SIZE; i++)
    begin : g_row
        tkfl_cell u_slot
        (
            .clk      (clk),
            .cell_idx (tkfl_pkg::POS_W'(i)),
            .ctrl     (ctrl),
            .link_in  (links[i]),
            .link_out (links[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
            done_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            accepted_reg <= ctrl.write_en;
            found_reg    <= last.hit;
            index_reg    <= last.hit_idx;
            word_reg     <= last.hit_key;
            freq_reg     <= last.hit_freq;
        end
    end

    assign done            = done_reg;
    assign accepted        = accepted_reg;
    assign found           = found_reg;
    assign entry_index     = index_reg;
    assign entry_word      = word_reg;
    assign entry_frequency = freq_reg;
    assign fill_count      = tkfl_pkg::FILL_W'(held_reg);

endmodule

/* hdl/tkfl_checker.sv */
// port-level checks for the top-k keyed frequency list, bound to the top level
// depends on tkfl_pkg and top_k_keyed_frequency_list_defines.svh
`timescale 1ns / 1ps
`include "top_k_keyed_frequency_list_defines.svh"

module tkfl_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          done,
    input  logic                          found,
    input  logic [tkfl_pkg::POS_W-1:0]    entry_index,
    input  logic [tkfl_pkg::KEY_W-1:0]    entry_word,
    input  logic [tkfl_pkg::FREQ_W-1:0]   entry_frequency,
    input  logic [tkfl_pkg::FILL_W-1:0]   fill_count
);

    // one result beat per command beat
    `TKFL_ASSERT_NEXT(a_done_follows, start && !busy, done)
    `TKFL_ASSERT_NEXT(a_no_stray_done, !(start && !busy), !done)
    // list never overfills
    `TKFL_ASSERT_NOW(a_fill_bound, 1'b1, fill_count <= tkfl_pkg::FILL_W'(tkfl_pkg::MAX_SIZE))
    // a hit points inside the held entries
    `TKFL_ASSERT_NOW(a_hit_in_range, done && found, entry_index < fill_count)
    // a miss reports zeros
    `TKFL_ASSERT_NOW(a_miss_zero, done && !found, entry_word == '0 && entry_frequency == '0)

endmodule

bind top_k_keyed_frequency_list tkfl_checker u_tkfl_checker (.*);
